// ----- rtl/quaternion_to_euler_angles_defines.svh -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - assertion macros
// Shared property shorthands for the checker, clocked on clock, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// same-cycle implication
`define QTEA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qtea checker: property failed");

// next-cycle implication
`define QTEA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qtea checker: property failed");

`endif

// ----- rtl/qtea_pkg.sv -----
// ----------------------------------------------------------------------------
// qtea_pkg
// Widths, constants, pole codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qtea_pkg;

   // datapath widths
   localparam int Q_W    = 16;  // component at Q15
   localparam int PROD_W = 32;  // Q30 product
   localparam int SUM_W  = 35;  // Q30 sums and doubled sums
   localparam int CRD_W  = 38;  // CORDIC vector with growth headroom
   localparam int ANG_W  = 27;  // angle in 2^-16 degree
   localparam int R_W    = 29;  // singular roll before wrap
   localparam int MAG_W  = 30;  // |2*test| in the regular case
   localparam int NRM_W  = 62;  // square root operand and partial root
   localparam int ISQ_N  = 31;  // one root bit per stage
   localparam int OUT_W  = 15;

   // constants
   localparam logic signed [SUM_W-1:0] ONE_Q30   = 35'sd1073741824;
   localparam logic signed [SUM_W-1:0] THRESH    = 35'sd536870375;
   localparam int                      FINE_180  = 11796480;
   localparam int                      FINE_360  = 23592960;
   localparam int                      ANGLE_LIM = 11520;
   localparam int                      PITCH_90  = 5760;

   typedef enum logic [1:0] {
      POLE_NONE = 2'd0,
      POLE_NEG  = 2'd1,
      POLE_POS  = 2'd2
   } pole_type;

   // atan(2^-i) in 2^-16 degree, rounded to nearest
   function automatic logic [22:0] atan_entry(input logic [4:0] idx);
      logic [22:0] v;
      case (idx)
         5'd0:    v = 23'd2949120;
         5'd1:    v = 23'd1740967;
         5'd2:    v = 23'd919879;
         5'd3:    v = 23'd466945;
         5'd4:    v = 23'd234379;
         5'd5:    v = 23'd117304;
         5'd6:    v = 23'd58666;
         5'd7:    v = 23'd29335;
         5'd8:    v = 23'd14668;
         5'd9:    v = 23'd7334;
         5'd10:   v = 23'd3667;
         5'd11:   v = 23'd1833;
         5'd12:   v = 23'd917;
         5'd13:   v = 23'd458;
         5'd14:   v = 23'd229;
         5'd15:   v = 23'd115;
         5'd16:   v = 23'd57;
         5'd17:   v = 23'd29;
         5'd18:   v = 23'd14;
         5'd19:   v = 23'd7;
         5'd20:   v = 23'd4;
         5'd21:   v = 23'd2;
         5'd22:   v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/qtea_cordic.sv -----
// ----------------------------------------------------------------------------
// qtea_cordic
// Pipelined vectoring CORDIC atan2: one quadrant-fold stage, then one
// micro-rotation per stage. Angle out in 2^-16 degree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qtea_cordic
   import qtea_pkg::*;
#(
   parameter int STAGES = 16
) (
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [CRD_W-1:0] vec_y,
   input  wire logic signed [CRD_W-1:0] vec_x,
   output logic signed [ANG_W-1:0]      angle
);

   logic signed [CRD_W-1:0] x_ff   [0:STAGES];
   logic signed [CRD_W-1:0] y_ff   [0:STAGES];
   logic signed [ANG_W-1:0] acc_ff [0:STAGES];
   logic                    zero_ff[0:STAGES];

   // fold left half-plane: negate vector, start at +-180
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (vec_x == '0) && (vec_y == '0);
         if (vec_x < 0) begin
            x_ff[0]   <= -vec_x;
            y_ff[0]   <= -vec_y;
            acc_ff[0] <= (vec_y < 0) ? -ANG_W'(FINE_180) : ANG_W'(FINE_180);
         end else begin
            x_ff[0]   <= vec_x;
            y_ff[0]   <= vec_y;
            acc_ff[0] <= '0;
         end
      end
   end

   // micro-rotations toward y = 0
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [ANG_W-1:0] STEP = ANG_W'(atan_entry(5'(i)));
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1]   <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] - (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] + STEP;
            end else begin
               x_ff[i+1]   <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] + (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] - STEP;
            end
         end
      end
   end

   // atan2(0, 0) is 0
   assign angle = zero_ff[STAGES] ? '0 : acc_ff[STAGES];

endmodule

`default_nettype wire

// ----- rtl/quaternion_to_euler_angles.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion to pitch, yaw and roll in 1/64 degree, with pole handling.
// ----------------------------------------------------------------------------
//  channel   ports                                    dir  meaning
//  req       req_valid/req_stall, req_quat_x..w        in   one quaternion
//  rsp       rsp_valid/rsp_stall, rsp_pitch/yaw/roll,  out  angles and pole
//            rsp_pole
//
//  One beat accepted per cycle while no rsp beat is held; the 31-stage square root
//  ahead of the pitch CORDIC plus the CORDIC depth set the pipeline depth.
//  Reset clears only the valid bits; data registers are not reset.
//  req_stall is high during reset.
//  A held rsp beat freezes the whole pipeline; req_stall follows it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_euler_angles
   import qtea_pkg::*;
#(
   parameter int CORDIC_STAGES   = 16,
   parameter int COMPONENT_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [OUT_W-1:0]                rsp_pitch_angle,
   output logic signed [OUT_W-1:0]                rsp_yaw_angle,
   output logic signed [OUT_W-1:0]                rsp_roll_angle,
   output logic [1:0]                             rsp_pole
);

   localparam int LC    = CORDIC_STAGES + 1;
   localparam int MID   = 2 + ISQ_N;           // S5, S6, root stages
   localparam int LAT   = 4 + MID + LC + 4;
   localparam int DN_SH = (COMPONENT_WIDTH > Q_W) ? COMPONENT_WIDTH - Q_W : 0;
   localparam int UP_SH = (COMPONENT_WIDTH < Q_W) ? Q_W - COMPONENT_WIDTH : 0;
   localparam int RND   = 512;
   localparam int RND_SH = 10;

   localparam logic [NRM_W-1:0] ONE_SQ = NRM_W'(1) << (2 * MAG_W);

   function automatic logic signed [Q_W-1:0] to_q15(
      input logic signed [COMPONENT_WIDTH-1:0] v);
      if (COMPONENT_WIDTH > Q_W) return Q_W'(v >>> DN_SH);
      return Q_W'(v) <<< UP_SH;
   endfunction

   function automatic logic signed [R_W-1:0] round_q(input logic signed [R_W-1:0] v);
      return (v + R_W'(RND)) >>> RND_SH;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [R_W-1:0] v);
      if (v > R_W'(ANGLE_LIM))  return OUT_W'(ANGLE_LIM);
      if (v < -R_W'(ANGLE_LIM)) return -OUT_W'(ANGLE_LIM);
      return OUT_W'(v);
   endfunction

   // global advance: held only while an output beat waits
   logic en;
   logic [LAT-1:0] vld_ff;

   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en || reset;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // S1: components to Q15
   logic signed [Q_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff <= to_q15(req_quat_x);
         qy_ff <= to_q15(req_quat_y);
         qz_ff <= to_q15(req_quat_z);
         qw_ff <= to_q15(req_quat_w);
      end
   end

   // S2: Q30 products
   logic signed [PROD_W-1:0] p_zx_ff, p_wy_ff, p_wz_ff, p_xy_ff, p_yy_ff;
   logic signed [PROD_W-1:0] p_zz_ff, p_wx_ff, p_yz_ff, p_xx_ff;
   logic signed [Q_W-1:0]    qx2_ff, qw2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         p_zx_ff <= qz_ff * qx_ff;
         p_wy_ff <= qw_ff * qy_ff;
         p_wz_ff <= qw_ff * qz_ff;
         p_xy_ff <= qx_ff * qy_ff;
         p_yy_ff <= qy_ff * qy_ff;
         p_zz_ff <= qz_ff * qz_ff;
         p_wx_ff <= qw_ff * qx_ff;
         p_yz_ff <= qy_ff * qz_ff;
         p_xx_ff <= qx_ff * qx_ff;
         qx2_ff  <= qx_ff;
         qw2_ff  <= qw_ff;
      end
   end

   // S3: test value and atan2 operands
   logic signed [SUM_W-1:0] test_ff, yaw_y_ff, yaw_x_ff, roll_y_ff, roll_x_ff;
   logic signed [Q_W-1:0]   qx3_ff, qw3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         test_ff   <= SUM_W'(p_zx_ff) - SUM_W'(p_wy_ff);
         yaw_y_ff  <= (SUM_W'(p_wz_ff) + SUM_W'(p_xy_ff)) <<< 1;
         yaw_x_ff  <= ONE_Q30 - ((SUM_W'(p_yy_ff) + SUM_W'(p_zz_ff)) <<< 1);
         roll_y_ff <= -((SUM_W'(p_wx_ff) + SUM_W'(p_yz_ff)) <<< 1);
         roll_x_ff <= ONE_Q30 - ((SUM_W'(p_xx_ff) + SUM_W'(p_yy_ff)) <<< 1);
         qx3_ff    <= qx2_ff;
         qw3_ff    <= qw2_ff;
      end
   end

   // S4: pole decision, roll operand select, |2*test|
   logic signed [SUM_W-1:0] s_in;
   logic                    sing;
   pole_type                pole_in;
   logic signed [CRD_W-1:0] roll_cy_in, roll_cx_in;
   logic [MAG_W-1:0]        mag_in;

   always_comb begin
      s_in    = test_ff <<< 1;
      sing    = (test_ff < -THRESH) || (test_ff > THRESH);
      pole_in = !sing ? POLE_NONE : (test_ff < 0) ? POLE_NEG : POLE_POS;
      mag_in  = (s_in < 0) ? MAG_W'(-s_in) : MAG_W'(s_in);
      if (sing) begin
         roll_cy_in = CRD_W'(qx3_ff) <<< (Q_W - 1);
         roll_cx_in = CRD_W'(qw3_ff) <<< (Q_W - 1);
      end else begin
         roll_cy_in = CRD_W'(roll_y_ff);
         roll_cx_in = CRD_W'(roll_x_ff);
      end
   end

   logic signed [CRD_W-1:0] yaw_cy_ff, yaw_cx_ff, roll_cy_ff, roll_cx_ff;
   logic signed [SUM_W-1:0] s4_ff;
   logic [MAG_W-1:0]        mag_ff;
   pole_type                pole4_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         yaw_cy_ff  <= CRD_W'(yaw_y_ff);
         yaw_cx_ff  <= CRD_W'(yaw_x_ff);
         roll_cy_ff <= roll_cy_in;
         roll_cx_ff <= roll_cx_in;
         s4_ff      <= s_in;
         mag_ff     <= mag_in;
         pole4_ff   <= pole_in;
      end
   end

   // S5: square of |s|
   logic [2*MAG_W-1:0]      sq_ff;
   logic signed [SUM_W-1:0] s5_ff;
   pole_type                pole5_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= mag_ff * mag_ff;
         s5_ff    <= s4_ff;
         pole5_ff <= pole4_ff;
      end
   end

   // S6 and root stages: floor(sqrt(2^60 - s^2)), one bit per stage
   logic [NRM_W-1:0]        n_a    [0:ISQ_N];
   logic [NRM_W-1:0]        res_a  [0:ISQ_N];
   logic signed [SUM_W-1:0] s_a    [0:ISQ_N];
   pole_type                pole_a [0:ISQ_N];
   logic [NRM_W-1:0]        bit_c  [0:ISQ_N-1];
   logic [NRM_W-1:0]        trial_c[0:ISQ_N-1];

   always_comb begin
      for (int k = 0; k < ISQ_N; k++) begin
         bit_c[k]   = NRM_W'(1) << (2 * (ISQ_N - 1 - k));
         trial_c[k] = res_a[k] + bit_c[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_a[0]    <= ONE_SQ - NRM_W'(sq_ff);
         res_a[0]  <= '0;
         s_a[0]    <= s5_ff;
         pole_a[0] <= pole5_ff;
         for (int k = 0; k < ISQ_N; k++) begin
            if (n_a[k] >= trial_c[k]) begin
               n_a[k+1]   <= n_a[k] - trial_c[k];
               res_a[k+1] <= (res_a[k] >> 1) + bit_c[k];
            end else begin
               n_a[k+1]   <= n_a[k];
               res_a[k+1] <= res_a[k] >> 1;
            end
            s_a[k+1]    <= s_a[k];
            pole_a[k+1] <= pole_a[k];
         end
      end
   end

   // atan2 units
   logic signed [ANG_W-1:0] yaw_f, roll_f, pitch_f;

   qtea_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
      .clock (clock),
      .en    (en),
      .vec_y (yaw_cy_ff),
      .vec_x (yaw_cx_ff),
      .angle (yaw_f)
   );

   qtea_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
      .clock (clock),
      .en    (en),
      .vec_y (roll_cy_ff),
      .vec_x (roll_cx_ff),
      .angle (roll_f)
   );

   qtea_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
      .clock (clock),
      .en    (en),
      .vec_y (CRD_W'(s_a[ISQ_N])),
      .vec_x (CRD_W'({1'b0, res_a[ISQ_N][MAG_W:0]})),
      .angle (pitch_f)
   );

   // align yaw/roll with pitch; carry pole through the pitch CORDIC
   logic signed [ANG_W-1:0] yaw_d [0:MID-1];
   logic signed [ANG_W-1:0] roll_d[0:MID-1];
   pole_type                pole_c[0:LC-1];

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_d[0]  <= yaw_f;
         roll_d[0] <= roll_f;
         for (int k = 1; k < MID; k++) begin
            yaw_d[k]  <= yaw_d[k-1];
            roll_d[k] <= roll_d[k-1];
         end
         pole_c[0] <= pole_a[ISQ_N];
         for (int k = 1; k < LC; k++) begin
            pole_c[k] <= pole_c[k-1];
         end
      end
   end

   // F1: round regular angles, form singular roll
   logic signed [ANG_W-1:0] yaw_al, roll_al;
   logic signed [R_W-1:0]   r_in;
   assign yaw_al  = yaw_d[MID-1];
   assign roll_al = roll_d[MID-1];

   always_comb begin
      if (pole_c[LC-1] == POLE_NEG) begin
         r_in = -R_W'(yaw_al) - (R_W'(roll_al) <<< 1);
      end else begin
         r_in = R_W'(yaw_al) - (R_W'(roll_al) <<< 1);
      end
   end

   logic signed [OUT_W-1:0] pitch1_ff, yaw1_ff, rreg1_ff;
   logic signed [R_W-1:0]   r1_ff;
   pole_type                pole1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         pitch1_ff <= sat_out(round_q(R_W'(pitch_f)));
         yaw1_ff   <= sat_out(round_q(R_W'(yaw_al)));
         rreg1_ff  <= sat_out(round_q(R_W'(roll_al)));
         r1_ff     <= r_in;
         pole1_ff  <= pole_c[LC-1];
      end
   end

   // F2, F3: wrap singular roll into (-180, 180]
   logic signed [R_W-1:0]   r2_in, r3_in, r2_ff, r3_ff;
   logic signed [OUT_W-1:0] pitch2_ff, yaw2_ff, rreg2_ff;
   logic signed [OUT_W-1:0] pitch3_ff, yaw3_ff, rreg3_ff;
   pole_type                pole2_ff, pole3_ff;

   always_comb begin
      if (r1_ff > R_W'(FINE_180))        r2_in = r1_ff - R_W'(FINE_360);
      else if (r1_ff <= -R_W'(FINE_180)) r2_in = r1_ff + R_W'(FINE_360);
      else                               r2_in = r1_ff;
      if (r2_ff > R_W'(FINE_180))        r3_in = r2_ff - R_W'(FINE_360);
      else if (r2_ff <= -R_W'(FINE_180)) r3_in = r2_ff + R_W'(FINE_360);
      else                               r3_in = r2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff     <= r2_in;
         pitch2_ff <= pitch1_ff;
         yaw2_ff   <= yaw1_ff;
         rreg2_ff  <= rreg1_ff;
         pole2_ff  <= pole1_ff;
         r3_ff     <= r3_in;
         pitch3_ff <= pitch2_ff;
         yaw3_ff   <= yaw2_ff;
         rreg3_ff  <= rreg2_ff;
         pole3_ff  <= pole2_ff;
      end
   end

   // F4: output register, pole selection
   logic signed [R_W-1:0]   rr;
   logic signed [OUT_W-1:0] roll_in, pitch_in;

   always_comb begin
      rr = round_q(r3_ff);
      if (rr <= -R_W'(ANGLE_LIM)) rr = R_W'(ANGLE_LIM);
      case (pole3_ff)
         POLE_NEG: begin
            pitch_in = -OUT_W'(PITCH_90);
            roll_in  = sat_out(rr);
         end
         POLE_POS: begin
            pitch_in = OUT_W'(PITCH_90);
            roll_in  = sat_out(rr);
         end
         default: begin
            pitch_in = pitch3_ff;
            roll_in  = rreg3_ff;
         end
      endcase
   end

   pole_type pole_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_pitch_angle <= pitch_in;
         rsp_yaw_angle   <= yaw3_ff;
         rsp_roll_angle  <= roll_in;
         pole_ff         <= pole3_ff;
      end
   end

   assign rsp_pole = pole_ff;

endmodule

`default_nettype wire

// ----- rtl/qtea_checker.sv -----
// ----------------------------------------------------------------------------
// qtea_checker
// Port-level properties of quaternion_to_euler_angles, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_euler_angles_defines.svh"

module qtea_checker
   import qtea_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic signed [OUT_W-1:0] rsp_pitch_angle,
   input wire logic signed [OUT_W-1:0] rsp_roll_angle,
   input wire logic [1:0]              rsp_pole
);

   // held result beat keeps its payload
   `QTEA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pitch_angle) && $stable(rsp_pole))

   // input side backs up only behind a held output beat
   `QTEA_ASSERT_NOW(a_req_stall, req_stall, rsp_valid && rsp_stall)

   // pole beats carry pitch of exactly +-90 degrees
   `QTEA_ASSERT_NOW(a_pole_pitch, rsp_valid && (rsp_pole != POLE_NONE), ((rsp_pole == POLE_POS) && (rsp_pitch_angle == OUT_W'(PITCH_90))) || ((rsp_pole == POLE_NEG) && (rsp_pitch_angle == -OUT_W'(PITCH_90))))

   // wrapped singular roll never shows -180
   `QTEA_ASSERT_NOW(a_pole_roll, rsp_valid && (rsp_pole != POLE_NONE), rsp_roll_angle != -OUT_W'(ANGLE_LIM))

endmodule

bind quaternion_to_euler_angles qtea_checker u_qtea_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pitch_angle (rsp_pitch_angle),
   .rsp_roll_angle  (rsp_roll_angle),
   .rsp_pole        (rsp_pole)
);

`default_nettype wire

// ----- tb/quaternion_to_euler_angles_checker.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - result checker
// Watches both channels. Each accepted quaternion beat is turned into the
// expected pitch, yaw, roll and pole by a bit-exact integer CORDIC model.
// Each accepted result beat is compared field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_euler_angles_checker
   import qtea_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic signed [15:0]      req_quat_x,
   input  logic signed [15:0]      req_quat_y,
   input  logic signed [15:0]      req_quat_z,
   input  logic signed [15:0]      req_quat_w,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [OUT_W-1:0] rsp_pitch_angle,
   input  logic signed [OUT_W-1:0] rsp_yaw_angle,
   input  logic signed [OUT_W-1:0] rsp_roll_angle,
   input  logic [1:0]              rsp_pole,
   output int                      fail_count,
   output int                      angles_pending
);

   localparam int STAGES = 16;
   localparam longint THRESH_Q30 = 536870375;
   localparam longint FINE_DEG = 65536;

   typedef struct packed {
      logic signed [OUT_W-1:0] pitch;
      logic signed [OUT_W-1:0] yaw;
      logic signed [OUT_W-1:0] roll;
      pole_type                pole;
   } euler_type;

   euler_type expected_angles[$];

   // arctangent of 2^-i in 2^-16 degree
   function automatic longint arctan_step(int i);
      longint steps[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      return steps[i];
   endfunction

   // vectoring CORDIC, result in 2^-16 degree
   function automatic longint vector_angle(longint y, longint x);
      longint acc, dx, dy;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         acc = (y < 0) ? -180 * FINE_DEG : 180 * FINE_DEG;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x = x + dy;
            y = y - dx;
            acc = acc + arctan_step(i);
         end else begin
            x = x - dy;
            y = y + dx;
            acc = acc - arctan_step(i);
         end
      end
      return acc;
   endfunction

   // floor square root
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint to_sixtyfourths(longint fine);
      return (fine + 512) >>> 10;
   endfunction

   function automatic longint clamp_angle(longint a);
      if (a > ANGLE_LIM) return ANGLE_LIM;
      if (a < -ANGLE_LIM) return -ANGLE_LIM;
      return a;
   endfunction

   function automatic euler_type predict_angles(longint x, longint y, longint z, longint w);
      euler_type e;
      longint one, test, yaw_fine, pivot, r, s;
      longint unsigned mag, c;
      one = 64'sd1 << 30;
      test = z * x - w * y;
      yaw_fine = vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
      e.yaw = OUT_W'(clamp_angle(to_sixtyfourths(yaw_fine)));
      if (test < -THRESH_Q30 || test > THRESH_Q30) begin
         // gimbal lock: roll follows yaw and the x/w angle
         pivot = vector_angle(x * 32768, w * 32768);
         if (test < 0) begin
            e.pitch = -OUT_W'(PITCH_90);
            r = -yaw_fine - 2 * pivot;
            e.pole = POLE_NEG;
         end else begin
            e.pitch = OUT_W'(PITCH_90);
            r = yaw_fine - 2 * pivot;
            e.pole = POLE_POS;
         end
         while (r > 180 * FINE_DEG) r = r - 360 * FINE_DEG;
         while (r <= -180 * FINE_DEG) r = r + 360 * FINE_DEG;
         r = to_sixtyfourths(r);
         if (r <= -ANGLE_LIM) r = ANGLE_LIM;
         e.roll = OUT_W'(clamp_angle(r));
      end else begin
         s = 2 * test;
         mag = (s < 0) ? -s : s;
         c = floor_sqrt((64'd1 << 60) - mag * mag);
         e.pitch = OUT_W'(clamp_angle(to_sixtyfourths(vector_angle(s, longint'(c)))));
         e.roll = OUT_W'(clamp_angle(to_sixtyfourths(vector_angle(-2 * (w * x + y * z),
                  one - 2 * (x * x + y * y)))));
         e.pole = POLE_NONE;
      end
      return e;
   endfunction

   assign angles_pending = expected_angles.size();

   // predict on request beats, compare on result beats
   always @(posedge clock) begin
      euler_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_angles.push_back(predict_angles(req_quat_x, req_quat_y,
                                                     req_quat_z, req_quat_w));
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $error("unexpected result beat");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_angles.pop_front();
               if (rsp_pitch_angle !== e.pitch || rsp_yaw_angle !== e.yaw ||
                   rsp_roll_angle !== e.roll || rsp_pole !== e.pole)
                  fail_count <= fail_count + 1;
               if (rsp_pitch_angle !== e.pitch)
                  $error("pitch_angle exp %0d got %0d", e.pitch, rsp_pitch_angle);
               if (rsp_yaw_angle !== e.yaw)
                  $error("yaw_angle exp %0d got %0d", e.yaw, rsp_yaw_angle);
               if (rsp_roll_angle !== e.roll)
                  $error("roll_angle exp %0d got %0d", e.roll, rsp_roll_angle);
               if (rsp_pole !== e.pole)
                  $error("pole exp %0d got %0d", e.pole, rsp_pole);
            end
         end
      end
   end

endmodule

// ----- tb/quaternion_to_euler_angles_tb.sv -----
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - testbench top
// Drives directed corner quaternions (poles, zero, extremes, axis turns),
// then near-unit random quaternions mixed with raw noise, with random gaps
// on both sides; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
   import qtea_pkg::*;

   localparam int RANDOM_BEATS = 1800;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic signed [15:0] req_quat_w = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [OUT_W-1:0] rsp_pitch_angle, rsp_yaw_angle, rsp_roll_angle;
   logic [1:0] rsp_pole;
   int fail_count;
   int angles_pending;
   bit stimulus_done = 1'b0;

   always #5 clock = ~clock;

   quaternion_to_euler_angles dut (.*);
   quaternion_to_euler_angles_checker checker_i (.*);

   // result side stalls at random after some beats, with calm stretches
   initial begin
      int calm;
      calm = 0;
      rsp_stall <= 1'b1;
      repeat (11) @(posedge clock);
      forever begin
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (calm > 0) calm--;
         else if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 80);
         else if ($urandom_range(0, 1)) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   // one beat, held until accepted, then, when gaps is set, sometimes a random gap
   task automatic send_quat(input logic [15:0] x, y, z, w, input bit gaps);
      req_valid <= 1'b1;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      req_quat_w <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (gaps && $urandom_range(0, 1)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // scaled so the sum of squares is close to 1.0 in Q30
   task automatic send_unit_quat(input bit gaps);
      longint c[4];
      longint unsigned n2, n;
      for (int i = 0; i < 4; i++) c[i] = longint'($signed(16'($urandom)));
      n2 = c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3];
      if (n2 == 0) n2 = 1;
      n = 1;
      while (n * n < n2) n++;
      for (int i = 0; i < 4; i++) begin
         c[i] = c[i] * 32767 / longint'(n);
         if ($urandom_range(0, 3) == 0) c[i] = c[i] + $urandom_range(0, 6) - 3;
         if (c[i] > 32767) c[i] = 32767;
         if (c[i] < -32768) c[i] = -32768;
      end
      send_quat(16'(c[0]), 16'(c[1]), 16'(c[2]), 16'(c[3]), gaps);
   endtask

   // stimulus
   initial begin
      int kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: identity, zero, extremes, poles, axis turns
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0);
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
      send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
      send_quat(16'sd0, 16'sd23170, 16'sd0, 16'sd23170, 1'b0);
      send_quat(16'sd0, -16'sd23170, 16'sd0, 16'sd23170, 1'b0);
      send_quat(16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384, 1'b0);
      send_quat(-16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0);
      send_quat(16'sd23170, 16'sd0, 16'sd23170, 16'sd0, 1'b0);
      send_quat(-16'sd23170, 16'sd0, 16'sd23170, 16'sd0, 1'b0);
      send_quat(16'sd23170, -16'sd23170, 16'sd0, 16'sd0, 1'b0);
      send_quat(16'sd23169, -16'sd23169, 16'sd0, 16'sd0, 1'b0);
      send_quat(16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0);
      send_quat(16'sd0, 16'sd0, 16'sd23170, 16'sd23170, 1'b0);
      send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0);
      send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b0);
      send_quat(16'sd0, 16'sd0, 16'sd1, -16'sd32768, 1'b0);
      send_quat(16'sd0, 16'sd0, -16'sd1, -16'sd32768, 1'b0);
      // hold off until every expected result is back
      req_valid <= 1'b0;
      @(posedge clock);
      while (angles_pending != 0) @(posedge clock);
      // random: mostly unit quaternions, some near poles, some raw noise
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            send_unit_quat(n % 300 < 250);
         end else if (kind < 8) begin
            // pole candidates: x near +1/sqrt(2), y near -1/sqrt(2), z and w at +-1/sqrt(2)
            send_quat(16'(16'sd23170 + $urandom_range(0, 8) - 4),
                      16'(-16'sd23170 + $urandom_range(0, 8) - 4),
                      $urandom_range(0, 1) ? 16'sd23170 : -16'sd23170,
                      $urandom_range(0, 1) ? 16'sd23170 : -16'sd23170,
                      n % 300 < 250);
         end else begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      n % 300 < 250);
         end
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // verdict
   initial begin
      wait (stimulus_done);
      while (angles_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS quaternion_to_euler_angles");
      else
         $display("FAIL quaternion_to_euler_angles");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAIL quaternion_to_euler_angles");
      $finish;
   end

endmodule
